// ----- design/pswt_pkg.sv -----
// ----------------------------------------------------------------------------
// pswt_pkg
// Shared types and constants for the plucked-string wavetable synthesizer.
// ----------------------------------------------------------------------------
package pswt_pkg;

	// item command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_PLUCK = 1'b1;

	// configuration register map (index bit of the byte address)
	localparam logic REG_DECAY_HOLD = 1'b0;

	// reset values
	localparam logic [3:0] DECAY_HOLD_RST = 4'd3;
	localparam logic [7:0] LENGTH_RST     = 8'd255;
	localparam logic [7:0] PREV_POS_RST   = 8'd255;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_FILL = 3'b100
	} state_t;

endpackage

// ----- design/plucked_string_wavetable_synth_unit.sv -----
// ----------------------------------------------------------------------------
// plucked_string_wavetable_synth_unit
// Plucked-string synthesizer over a byte wavetable held in one synchronous
// memory; ticks smooth the table in place, plucks refill it with a sawtooth.
// ----------------------------------------------------------------------------
// A tick item reads the table memory at the accept edge (current and previous
// entry on two read ports); in the execute state the smoothed entry is written
// back, when the decay counter is zero, as the sample is loaded into the output
// register, which can wait while an earlier sample stalls. A pluck with length
// L refills L entries, one table entry per cycle through the single write port;
// a pluck of length zero does no refill. One item is worked on at a time, and
// a new item is taken while a finished sample still waits on the output. Table
// entries never written read as zero through per-entry valid bits, so there is
// no clearing pass after reset.
module plucked_string_wavetable_synth_unit #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command items
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        command,
	input  logic [7:0]  period_length,
	// sample items
	output logic        sample_valid,
	input  logic        sample_stall,
	output logic [7:0]  sample
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] SLOT_LAST    = AW'(TABLE_DEPTH - 1);
	localparam logic [AW-1:0] PREV_SLOT_RST = AW'(255 % TABLE_DEPTH);

	pswt_pkg::state_t state_q;

	logic [3:0]    decay_hold_q;
	logic [7:0]    rd_pos_q;
	logic [AW-1:0] rd_slot_q;
	logic [AW-1:0] prv_slot_q;
	logic [7:0]    len_q;
	logic [3:0]    dcy_q;
	logic [7:0]    fill_q;
	logic [AW-1:0] fill_slot_q;
	logic          sample_valid_q;
	logic [7:0]    sample_q;

	logic [7:0]    table_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;
	logic [7:0]    cur_raw_s1;
	logic [7:0]    prv_raw_s1;
	logic          cur_vld_s1;
	logic          prv_vld_s1;

	logic          item_acc;
	logic          tick_acc;
	logic          commit;
	logic [7:0]    cur_val;
	logic [7:0]    prv_val;
	logic [7:0]    smooth_val;
	logic [7:0]    fill_val;
	logic [7:0]    pos_inc;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic          cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == pswt_pkg::REG_DECAY_HOLD);
	assign prdata = (paddr[2] == pswt_pkg::REG_DECAY_HOLD) ? {28'd0, decay_hold_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_hold_q <= pswt_pkg::DECAY_HOLD_RST;
		end else if (cfg_wr) begin
			decay_hold_q <= pwdata[3:0];
		end
	end

	// handshakes
	assign item_stall   = (state_q != pswt_pkg::ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign tick_acc     = item_acc && (command == pswt_pkg::CMD_TICK);
	assign commit       = (state_q == pswt_pkg::ST_EXEC) && !(sample_valid_q && sample_stall);
	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;

	// table data, unwritten entries read as zero
	assign cur_val    = cur_vld_s1 ? cur_raw_s1 : 8'd0;
	assign prv_val    = prv_vld_s1 ? prv_raw_s1 : 8'd0;
	assign smooth_val = {1'b0, cur_val[7:1]} + {1'b0, prv_val[7:1]};
	assign fill_val   = (fill_q < {1'b0, len_q[7:1]}) ? fill_q : (fill_q - len_q);
	assign pos_inc    = rd_pos_q + 8'd1;

	// write port: refill or smoothing write-back
	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_slot_q;
		mem_wd = smooth_val;
		if (state_q == pswt_pkg::ST_FILL) begin
			mem_we = 1'b1;
			mem_wa = fill_slot_q;
			mem_wd = fill_val;
		end else if (commit && (dcy_q == 4'd0)) begin
			mem_we = 1'b1;
		end
	end

	// wavetable memory, two read ports with registered data
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_wa] <= mem_wd;
		end
		if (tick_acc) begin
			cur_raw_s1 <= table_mem[rd_slot_q];
			prv_raw_s1 <= table_mem[prv_slot_q];
		end
	end

	// written-entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			cur_vld_s1 <= 1'b0;
			prv_vld_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			if (tick_acc) begin
				cur_vld_s1 <= vld_q[rd_slot_q];
				prv_vld_s1 <= vld_q[prv_slot_q];
			end
		end
	end

	// sequencer, positions and decay counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pswt_pkg::ST_IDLE;
			rd_pos_q    <= 8'd0;
			rd_slot_q   <= '0;
			prv_slot_q  <= PREV_SLOT_RST;
			len_q       <= pswt_pkg::LENGTH_RST;
			dcy_q       <= 4'd0;
			fill_q      <= 8'd0;
			fill_slot_q <= '0;
		end else begin
			unique case (state_q)
				pswt_pkg::ST_IDLE: begin
					if (item_acc) begin
						if (command == pswt_pkg::CMD_PLUCK) begin
							len_q       <= period_length;
							fill_q      <= 8'd0;
							fill_slot_q <= '0;
							if (period_length != 8'd0) begin
								state_q <= pswt_pkg::ST_FILL;
							end
						end else begin
							state_q <= pswt_pkg::ST_EXEC;
						end
					end
				end
				pswt_pkg::ST_EXEC: begin
					if (commit) begin
						state_q    <= pswt_pkg::ST_IDLE;
						prv_slot_q <= rd_slot_q;
						if (pos_inc == len_q) begin
							rd_pos_q  <= 8'd0;
							rd_slot_q <= '0;
							dcy_q     <= (dcy_q == decay_hold_q) ? 4'd0 : dcy_q + 4'd1;
						end else begin
							rd_pos_q <= pos_inc;
							if (pos_inc == 8'd0 || rd_slot_q == SLOT_LAST) begin
								rd_slot_q <= '0;
							end else begin
								rd_slot_q <= rd_slot_q + AW'(1);
							end
						end
					end
				end
				pswt_pkg::ST_FILL: begin
					fill_q      <= fill_q + 8'd1;
					fill_slot_q <= (fill_slot_q == SLOT_LAST) ? '0 : fill_slot_q + AW'(1);
					if (fill_q == len_q - 8'd1) begin
						state_q <= pswt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pswt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid_q <= 1'b0;
		end else if (commit) begin
			sample_valid_q <= 1'b1;
		end else if (!sample_stall) begin
			sample_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			sample_q <= cur_val;
		end
	end

	// checks
	a_tick_execs: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> state_q == pswt_pkg::ST_EXEC)
		else $error("accepted tick did not enter execute");

	a_pluck_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && command == pswt_pkg::CMD_PLUCK && period_length != 8'd0)
		|=> state_q == pswt_pkg::ST_FILL)
		else $error("pluck did not start refill");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pswt_pkg::ST_FILL |-> fill_q < len_q)
		else $error("refill ran past period length");

	a_sample_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid_q) |-> $past(state_q) == pswt_pkg::ST_EXEC)
		else $error("sample appeared without a tick");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pswt_pkg::ST_IDLE |-> !mem_we)
		else $error("table written while idle");

endmodule
